// ===== design/mgd_pkg.sv =====
package mgd_pkg;

  localparam int IN_W      = 32;
  localparam int DIST_W    = 48;
  localparam int NUM_W     = 100;
  localparam int DET_W     = 63;
  localparam int DIV_STEPS = 48;
  localparam int PIPE_LAT  = 55;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNASSOC = 2'd1;
  localparam logic [1:0] ST_NOT_PD  = 2'd2;
  localparam logic [1:0] ST_SAT     = 2'd3;

  typedef struct packed {
    logic signed [IN_W-1:0] meas_x;
    logic signed [IN_W-1:0] meas_y;
    logic signed [IN_W-1:0] pred_x;
    logic signed [IN_W-1:0] pred_y;
    logic signed [IN_W-1:0] cov_xx;
    logic signed [IN_W-1:0] cov_xy;
    logic signed [IN_W-1:0] cov_yy;
    logic                   is_associated;
  } in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [1:0]        status;
  } out_t;

endpackage

// ===== design/mahalanobis_2d_gate_distance_unit.sv =====
// Each request passes through the arithmetic stages, a divider load register,
// 48 divider stages of one quotient bit each, and the output register; its result
// is shown with strobe out_valid high for one cycle.
// Throughput: one request per cycle; busy stays low, the receiver cannot stall.
// Reset (rst_n low, synchronous) clears all stage valid bits; data is not reset.
module mahalanobis_2d_gate_distance_unit
  import mgd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  // stage 1: innovation
  logic                   v1_r, as1_r;
  logic signed [32:0]     dx1_r, dy1_r;
  logic signed [IN_W-1:0] sxx1_r, sxy1_r, syy1_r;

  // stage 2: products of inputs
  logic                   v2_r, as2_r;
  logic signed [65:0]     dxx2_r, dyy2_r, dxy2_r;
  logic signed [63:0]     sxxyy2_r, sxy_sq2_r;
  logic signed [IN_W-1:0] sxx2_r, sxy2_r, syy2_r;

  // stage 3: partial products, determinant
  logic                   v3_r, as3_r, pos3_r;
  logic signed [63:0]     det3_r;
  logic signed [64:0]     a_lo3_r, b_lo3_r, c_lo3_r;
  logic signed [65:0]     a_hi3_r, b_hi3_r, c_hi3_r;

  // stage 4: full terms
  logic                   v4_r, as4_r, pd4_r;
  logic signed [NUM_W-1:0] ta4_r, tb4_r, tc4_r;
  logic [DET_W-1:0]       det4_r;

  // stage 5: numerator
  logic                   v5_r, as5_r, pd5_r;
  logic signed [NUM_W-1:0] num5_r;
  logic [DET_W-1:0]       det5_r;

  // divider stages; index 0 is loaded from stage 5
  logic                   dv_r   [DIV_STEPS+1];
  logic [1:0]             dst_r  [DIV_STEPS+1];
  logic [DET_W-1:0]       drem_r [DIV_STEPS+1];
  logic [DIST_W-1:0]      dlow_r [DIV_STEPS+1];
  logic [DET_W-1:0]       ddet_r [DIV_STEPS+1];

  logic                   out_valid_r;
  out_t                   out_data_r;

  logic [51:0]            num_top;
  logic                   ovf;
  logic [1:0]             st0;

  assign num_top = num5_r[NUM_W-1:48];
  assign ovf     = {11'b0, num_top} >= det5_r;

  always_comb begin
    if (!as5_r) begin
      st0 = ST_UNASSOC;
    end else if (!pd5_r) begin
      st0 = ST_NOT_PD;
    end else if (ovf) begin
      st0 = ST_SAT;
    end else begin
      st0 = ST_OK;
    end
  end

  // arithmetic stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end

    as1_r  <= in_data.is_associated;
    dx1_r  <= 33'(in_data.meas_x) - 33'(in_data.pred_x);
    dy1_r  <= 33'(in_data.meas_y) - 33'(in_data.pred_y);
    sxx1_r <= in_data.cov_xx;
    sxy1_r <= in_data.cov_xy;
    syy1_r <= in_data.cov_yy;

    as2_r     <= as1_r;
    dxx2_r    <= dx1_r * dx1_r;
    dyy2_r    <= dy1_r * dy1_r;
    dxy2_r    <= dx1_r * dy1_r;
    sxxyy2_r  <= sxx1_r * syy1_r;
    sxy_sq2_r <= sxy1_r * sxy1_r;
    sxx2_r    <= sxx1_r;
    sxy2_r    <= sxy1_r;
    syy2_r    <= syy1_r;

    as3_r   <= as2_r;
    pos3_r  <= !sxx2_r[IN_W-1] && (sxx2_r != '0) && !syy2_r[IN_W-1] && (syy2_r != '0);
    det3_r  <= sxxyy2_r - sxy_sq2_r;
    a_lo3_r <= $signed({1'b0, dxx2_r[31:0]}) * syy2_r;
    a_hi3_r <= $signed(dxx2_r[65:32]) * syy2_r;
    b_lo3_r <= $signed({1'b0, dyy2_r[31:0]}) * sxx2_r;
    b_hi3_r <= $signed(dyy2_r[65:32]) * sxx2_r;
    c_lo3_r <= $signed({1'b0, dxy2_r[31:0]}) * sxy2_r;
    c_hi3_r <= $signed(dxy2_r[65:32]) * sxy2_r;

    as4_r  <= as3_r;
    pd4_r  <= pos3_r && !det3_r[63] && (det3_r != '0);
    det4_r <= det3_r[DET_W-1:0];
    ta4_r  <= (NUM_W'(a_hi3_r) <<< 32) + NUM_W'(a_lo3_r);
    tb4_r  <= (NUM_W'(b_hi3_r) <<< 32) + NUM_W'(b_lo3_r);
    tc4_r  <= (NUM_W'(c_hi3_r) <<< 32) + NUM_W'(c_lo3_r);

    as5_r  <= as4_r;
    pd5_r  <= pd4_r;
    det5_r <= det4_r;
    num5_r <= ta4_r + tb4_r - (tc4_r <<< 1);
  end

  // restoring divider, one quotient bit per stage; quotient shifts into dlow
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= DIV_STEPS; k++) begin
        dv_r[k] <= 1'b0;
      end
    end else begin
      dv_r[0] <= v5_r;
      for (int k = 0; k < DIV_STEPS; k++) begin
        dv_r[k+1] <= dv_r[k];
      end
    end

    dst_r[0]  <= st0;
    drem_r[0] <= {11'b0, num_top};
    dlow_r[0] <= num5_r[DIST_W-1:0];
    ddet_r[0] <= det5_r;
    for (int k = 0; k < DIV_STEPS; k++) begin
      logic [DET_W:0] t;
      logic           ge;
      t  = {drem_r[k], dlow_r[k][DIST_W-1]};
      ge = t >= {1'b0, ddet_r[k]};
      dst_r[k+1]  <= dst_r[k];
      ddet_r[k+1] <= ddet_r[k];
      drem_r[k+1] <= ge ? DET_W'(t - {1'b0, ddet_r[k]}) : t[DET_W-1:0];
      dlow_r[k+1] <= {dlow_r[k][DIST_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_r[DIV_STEPS];
    end
    out_data_r.status   <= dst_r[DIV_STEPS];
    out_data_r.distance <= (dst_r[DIV_STEPS] == ST_OK) ? dlow_r[DIV_STEPS] : DIST_MAX;
  end

  assign busy      = 1'b0;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/mgd_checker.sv =====
module mgd_checker
  import mgd_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input in_t  in_data,
  input logic out_valid,
  input out_t out_data
);

  // every request yields a result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LAT out_valid)
    else $error("result missing after request");

  a_unassoc: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_data.is_associated) |-> ##PIPE_LAT
      (out_data.status == ST_UNASSOC))
    else $error("unassociated request without infinite status");

  a_flag_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != ST_OK)) |-> (out_data.distance == DIST_MAX))
    else $error("flagged result without saturated distance");

  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

endmodule

bind mahalanobis_2d_gate_distance_unit mgd_checker u_mgd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

// ===== sim/testbench.sv =====
module testbench
  import mgd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;

  in_t  req_queue[$];
  out_t gate_expected[$];
  int   send_idle_pct;
  int   errors = 0;
  int   cycle_count = 0;
  bit   stim_done;

  localparam int CYCLE_LIMIT = 400000;

  mahalanobis_2d_gate_distance_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Exact normalized innovation squared with the gating rules.
  function automatic out_t gate_distance(input in_t r);
    out_t o;
    logic signed [63:0] det;
    logic signed [33:0] dx, dy;
    logic signed [131:0] num, lim;
    logic [131:0] q;
    if (!r.is_associated) begin
      o.distance = DIST_MAX;
      o.status = ST_UNASSOC;
      return o;
    end
    det = 64'(r.cov_xx) * 64'(r.cov_yy) - 64'(r.cov_xy) * 64'(r.cov_xy);
    if (r.cov_xx <= 0 || r.cov_yy <= 0 || det <= 0) begin
      o.distance = DIST_MAX;
      o.status = ST_NOT_PD;
      return o;
    end
    dx = 34'(r.meas_x) - 34'(r.pred_x);
    dy = 34'(r.meas_y) - 34'(r.pred_y);
    num = 132'(r.cov_yy) * dx * dx - 132'sd2 * 132'(r.cov_xy) * dx * dy
          + 132'(r.cov_xx) * dy * dy;
    lim = 132'(det) <<< 48;
    if (num >= lim) begin
      o.distance = DIST_MAX;
      o.status = ST_SAT;
      return o;
    end
    q = 132'(num) / 132'(det);
    o.distance = q[DIST_W-1:0];
    o.status = ST_OK;
    return o;
  endfunction

  function automatic in_t random_request(input int mode);
    in_t r;
    int unsigned sc;
    r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 1'b1};
    if (mode < 70) begin
      // well-formed: positive diagonal covariance with a reduced off-diagonal term, moderate innovation
      sc = $urandom_range(24, 4);
      r.cov_xx = 32'($urandom_range(32'h7fffffff >> sc, 1));
      r.cov_yy = 32'($urandom_range(32'h7fffffff >> sc, 1));
      r.cov_xy = $signed(32'($urandom)) >>> ($urandom_range(31, sc + 1));
      r.pred_x = $signed(r.meas_x) + ($signed(32'($urandom)) >>> $urandom_range(31, 8));
      r.pred_y = $signed(r.meas_y) + ($signed(32'($urandom)) >>> $urandom_range(31, 8));
    end else if (mode < 80) begin
      r.is_associated = 1'b0;
    end else if (mode < 90) begin
      r.cov_xx = 32'($urandom_range(32'h7fffffff, 1));
      r.cov_yy = 32'($urandom_range(32'h7fffffff, 1));
    end
    return r;
  endfunction

  task automatic add_request(input in_t r);
    req_queue = {req_queue, r};
    gate_expected = {gate_expected, gate_distance(r)};
  endtask

  initial begin
    in_t r;
    logic signed [31:0] edge_vals[6] = '{32'sh7fffffff, 32'sh80000000, 0, 1, -1, 32'sh10000};
    send_idle_pct = 20;
    stim_done = 1'b0;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    r = '{default: 0};
    add_request(r);
    r.is_associated = 1'b1;
    add_request(r);
    r.cov_xx = 32'sh10000; r.cov_yy = 32'sh10000;
    add_request(r);
    r.meas_x = 32'sh7fffffff; r.pred_x = 32'sh80000000;
    r.meas_y = 32'sh80000000; r.pred_y = 32'sh7fffffff;
    add_request(r);
    r.cov_xx = 1; r.cov_yy = 1;
    add_request(r);
    r.cov_xx = 32'sh7fffffff; r.cov_yy = 32'sh7fffffff; r.cov_xy = 32'sh80000001;
    add_request(r);
    r.cov_xy = 32'sh7fffffff;
    add_request(r);
    r.cov_xx = 32'sh80000000;
    add_request(r);
    r.cov_xx = 32'sh10000; r.cov_yy = -1;
    add_request(r);
    r.cov_yy = 32'sh10000; r.cov_xy = 32'sh10000;
    add_request(r);
    r.meas_x = 32'sh30000; r.pred_x = 0; r.meas_y = -32'sh20000; r.pred_y = 0;
    r.cov_xy = 32'sh8000;
    add_request(r);
    r.is_associated = 1'b0;
    add_request(r);
    for (int i = 0; i < 12; i++) begin
      r.meas_x = edge_vals[$urandom_range(5)]; r.pred_x = edge_vals[$urandom_range(5)];
      r.meas_y = edge_vals[$urandom_range(5)]; r.pred_y = edge_vals[$urandom_range(5)];
      r.cov_xx = edge_vals[$urandom_range(5)]; r.cov_yy = edge_vals[$urandom_range(5)];
      r.cov_xy = edge_vals[$urandom_range(5)]; r.is_associated = 1'b1;
      add_request(r);
    end
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 71 : 0;
      for (int i = 0; i < 560; i++) add_request(random_request($urandom_range(99)));
      wait (req_queue.size() == 0);
    end
    stim_done = 1'b1;
  end

  // driver: the queue head is the request on the ports; drop it once accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_data <= '0;
    end else begin
      if (start && !busy) void'(req_queue.pop_front());
      if (req_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        start <= 1'b1;
        in_data <= req_queue[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_t exp_o;
    if (rst_n && out_valid) begin
      if (gate_expected.size() == 0) begin
        $error("result with no request pending: distance %h status %0d",
               out_data.distance, out_data.status);
        errors++;
      end else begin
        exp_o = gate_expected.pop_front();
        if (out_data.distance !== exp_o.distance) begin
          $error("distance expected %h actual %h", exp_o.distance, out_data.distance);
          errors++;
        end
        if (out_data.status !== exp_o.status) begin
          $error("status expected %0d actual %0d", exp_o.status, out_data.status);
          errors++;
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    wait (gate_expected.size() == 0);
    repeat (PIPE_LAT + 10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS mahalanobis_2d_gate_distance_unit");
    end else begin
      $display("FAIL mahalanobis_2d_gate_distance_unit");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL mahalanobis_2d_gate_distance_unit");
      $finish;
    end
  end

endmodule
